// File: rtl/stal_pkg.sv
package stal_pkg;

    // default table depth
    localparam int STAL_SLOTS = 16;

    // field widths of the stream beats
    localparam int KIND_W    = 2;
    localparam int IDX_IN_W  = 4;
    localparam int PROC_W    = 22;
    localparam int TERM_W    = 8;
    localparam int SLOT_W    = 4;
    localparam int SPAN_W    = 5;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;
    localparam int ENTRY_W   = PROC_W + TERM_W;

    // operation codes carried in the slave tuser
    localparam logic [KIND_W-1:0] KIND_ALLOC     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIND_PROC = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FIND_TERM = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_FREE,
        ST_FIND
    } t_state;

endpackage

// File: rtl/slot_table_alloc_lookup_unit.sv
// channel   dir  tdata (low bit up)                              tuser
// s_axis    in   slot_index[3:0] proc_id[25:4] term_num[33:26]  kind[1:0]
// m_axis    out  slot_out[3:0] in_use_span[8:4]                  status[0]
//
// one operation at a time: s_axis_tready is high only while the sequencer is idle
// allocate and find walk the table one slot a cycle, up to the high-water count r_hw;
// free clears the slot on the accepting beat, then trims trailing free slots one a cycle
// the result sits in an output register; the next beat is taken as soon as it is loaded
// a stalled m_axis holds the finishing step until the output register frees up
// synchronous active-low reset clears the occupied bits, the count and the sequencer
module slot_table_alloc_lookup_unit import stal_pkg::*; #(
    parameter int SLOTS = STAL_SLOTS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // slot_index, proc_id, term_num, zero pad
    input  logic [KIND_W-1:0]    s_axis_tuser,   // kind
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // slot_out, in_use_span, zero pad
    output logic                 m_axis_tuser    // status
);

    // index width for the table, count width able to hold SLOTS itself
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    t_state r_state, n_state;

    // scan counter, compare stage behind the memory read
    logic [CW-1:0] r_idx, n_idx;
    logic          r_cmp_vld, n_cmp_vld;
    logic [IW-1:0] r_cmp_idx, n_cmp_idx;

    // table state: occupied bits in flops, keys in memory
    logic [CW-1:0]    r_hw, n_hw;
    logic [SLOTS-1:0] r_occ, n_occ;
    logic [ENTRY_W-1:0] r_mem [SLOTS];
    logic [ENTRY_W-1:0] r_rd_data;

    // operation held for the length of the walk
    logic [KIND_W-1:0] r_kind;
    logic [PROC_W-1:0] r_key_proc;
    logic [TERM_W-1:0] r_key_term;
    logic [IW-1:0]     r_free_idx;
    logic              r_free_bad;

    // output register
    logic              r_m_valid, n_m_valid;
    logic              r_m_status;
    logic [SLOT_W-1:0] r_m_slot;
    logic [SPAN_W-1:0] r_m_span;

    logic               w_accept;
    logic               w_out_free;
    logic               w_load;
    logic               w_res_status;
    logic [IW-1:0]      w_res_slot;
    logic               w_wr_en;
    logic [IW-1:0]      w_wr_addr;
    logic               w_rd_en;
    logic [IW-1:0]      w_rd_addr;
    logic [CW-1:0]      w_hw_m1;
    logic               w_match;
    logic [IDX_IN_W-1:0] w_in_idx;
    logic               w_in_bad;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_m_valid || m_axis_tready;

    assign w_in_idx = s_axis_tdata[IDX_IN_W-1:0];
    // slot numbers beyond the table are refused on free
    assign w_in_bad = ({{(32-IDX_IN_W){1'b0}}, w_in_idx} >= 32'(SLOTS));

    assign w_hw_m1   = r_hw - 1'b1;
    assign w_rd_addr = (r_idx < CW'(SLOTS)) ? r_idx[IW-1:0] : '0;
    assign w_match   = (r_kind == KIND_FIND_PROC) ?
                       (r_rd_data[ENTRY_W-1:TERM_W] == r_key_proc) :
                       (r_rd_data[TERM_W-1:0] == r_key_term);

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tdata  = {{(M_TDATA_W-SLOT_W-SPAN_W){1'b0}}, r_m_span, r_m_slot};

    // sequencer: next state, scan steps and result
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_cmp_vld    = r_cmp_vld;
        n_cmp_idx    = r_cmp_idx;
        n_hw         = r_hw;
        n_occ        = r_occ;
        n_m_valid    = r_m_valid && !m_axis_tready;
        w_load       = 1'b0;
        w_res_status = 1'b0;
        w_res_slot   = '0;
        w_wr_en      = 1'b0;
        w_wr_addr    = '0;
        w_rd_en      = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_idx     = '0;
                    n_cmp_vld = 1'b0;
                    case (s_axis_tuser)
                        KIND_ALLOC: begin
                            n_state = ST_ALLOC;
                        end
                        KIND_FREE: begin
                            if (!w_in_bad) begin
                                n_occ[IW'(w_in_idx)] = 1'b0;
                            end
                            n_state = ST_FREE;
                        end
                        default: begin
                            n_state = ST_FIND;
                        end
                    endcase
                end
            end

            ST_ALLOC: begin
                if (r_idx >= r_hw) begin
                    // no hole below the count: extend or report full
                    if (w_out_free) begin
                        w_load  = 1'b1;
                        n_state = ST_IDLE;
                        if (r_hw == CW'(SLOTS)) begin
                            w_res_status = 1'b1;
                        end else begin
                            w_wr_en           = 1'b1;
                            w_wr_addr         = r_hw[IW-1:0];
                            n_occ[r_hw[IW-1:0]] = 1'b1;
                            n_hw              = r_hw + 1'b1;
                            w_res_slot        = r_hw[IW-1:0];
                        end
                    end
                end else if (!r_occ[r_idx[IW-1:0]]) begin
                    if (w_out_free) begin
                        w_load               = 1'b1;
                        n_state              = ST_IDLE;
                        w_wr_en              = 1'b1;
                        w_wr_addr            = r_idx[IW-1:0];
                        n_occ[r_idx[IW-1:0]] = 1'b1;
                        w_res_slot           = r_idx[IW-1:0];
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            ST_FREE: begin
                if (r_free_bad) begin
                    if (w_out_free) begin
                        w_load       = 1'b1;
                        n_state      = ST_IDLE;
                        w_res_status = 1'b1;
                    end
                end else if ((r_hw != '0) && !r_occ[w_hw_m1[IW-1:0]]) begin
                    // trim one trailing free slot a cycle
                    n_hw = w_hw_m1;
                end else if (w_out_free) begin
                    w_load     = 1'b1;
                    n_state    = ST_IDLE;
                    w_res_slot = r_free_idx;
                end
            end

            ST_FIND: begin
                if (r_cmp_vld && w_match) begin
                    if (w_out_free) begin
                        w_load     = 1'b1;
                        n_state    = ST_IDLE;
                        w_res_slot = r_cmp_idx;
                    end
                end else if (r_idx >= r_hw) begin
                    if (w_out_free) begin
                        w_load       = 1'b1;
                        n_state      = ST_IDLE;
                        w_res_status = 1'b1;
                    end
                end else begin
                    // read next slot, compare it in the following cycle
                    w_rd_en   = 1'b1;
                    n_idx     = r_idx + 1'b1;
                    n_cmp_vld = r_occ[r_idx[IW-1:0]];
                    n_cmp_idx = r_idx[IW-1:0];
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_load) begin
            n_m_valid = 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_cmp_idx <= '0;
            r_hw      <= '0;
            r_occ     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_cmp_vld <= n_cmp_vld;
            r_cmp_idx <= n_cmp_idx;
            r_hw      <= n_hw;
            r_occ     <= n_occ;
            r_m_valid <= n_m_valid;
        end
    end

    // operation payload, latched on the accepting beat
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind     <= s_axis_tuser;
            r_key_proc <= s_axis_tdata[IDX_IN_W +: PROC_W];
            r_key_term <= s_axis_tdata[IDX_IN_W + PROC_W +: TERM_W];
            r_free_idx <= IW'(w_in_idx);
            r_free_bad <= w_in_bad;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_m_status <= w_res_status;
            r_m_slot   <= SLOT_W'(w_res_slot);
            r_m_span   <= SPAN_W'(n_hw);
        end
    end

    // key memory, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= {r_key_proc, r_key_term};
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

endmodule
